/* hw/rtl/lcbfs_pkg.sv */
// Shared types, constants and lookup tables of the LED cube BAM frame store.
package lcbfs_pkg;

  localparam int ROW_COUNT     = 4;
  localparam int COL_COUNT     = 4;
  localparam int LAYER_COUNT   = 4;
  localparam int PLANES        = 4;
  localparam int VOX_PER_LAYER = ROW_COUNT * COL_COUNT;
  localparam int VOX_TOTAL     = VOX_PER_LAYER * LAYER_COUNT;
  localparam int BYTES         = (VOX_PER_LAYER * 3 + 7) / 8;
  localparam int STORE_SIZE    = LAYER_COUNT * PLANES * BYTES;
  localparam int USED_BITS     = (VOX_PER_LAYER * 3) % 8;
  localparam logic [7:0] PAD_MASK = (USED_BITS == 0) ? 8'hFF : 8'((1 << USED_BITS) - 1);

  localparam int IDX_RANGE = 256;
  localparam int RANGE_W   = 10;
  localparam int LAYER_W   = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int POS_W     = (VOX_PER_LAYER > 1) ? $clog2(VOX_PER_LAYER) : 1;
  localparam int Q_W       = ($clog2(3 * VOX_PER_LAYER) > 3) ? $clog2(3 * VOX_PER_LAYER) : 3;
  localparam int BYTE_W    = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int ADDR_W    = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int CNT_W     = $clog2(STORE_SIZE + 1);
  // two byte visits per plane for one voxel
  localparam int VOX_STEPS = 2 * PLANES;

  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_READ    = 3'd1,
    FN_ALL_ON  = 3'd2,
    FN_ALL_OFF = 3'd3,
    FN_SYNC    = 3'd4,
    FN_SHIFT   = 3'd5
  } func_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] voxel_index;
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
    logic       force_req;
    logic [2:0] layer_sel;
    logic [4:0] bam_tick;
  } item_t;

  typedef struct packed {
    logic [11:0] color_word;
    logic [7:0]  shift_byte;
    logic        last;
    logic        dirty;
  } result_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_FILL,
    OP_COPY,
    OP_WR_RD,
    OP_WR_WR,
    OP_RD_RD,
    OP_RD_ACC,
    OP_SH_RD
  } dp_op_e;

  typedef enum logic [1:0] {
    OSEL_STATUS,
    OSEL_PLANE,
    OSEL_SELECT
  } out_sel_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_WR_RD,
    S_WR_WR,
    S_RD_RD,
    S_RD_ACC,
    S_FILL,
    S_COPY,
    S_RESULT,
    S_SH_RD,
    S_SH_OUT,
    S_SH_SEL
  } state_e;

  typedef struct packed {
    dp_op_e   op;
    logic     load_item;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     dirty_set;
    logic     dirty_clr;
    logic     out_load;
    out_sel_e out_sel;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  force_req;
    logic  in_range;
    logic  shift_ok;
    logic  step_last;
    logic  byte_last;
    logic  store_last;
    logic  at_store;
    logic  out_free;
  } dp_sts_t;

  typedef logic [IDX_RANGE-1:0][LAYER_W-1:0] layer_lut_t;
  typedef logic [IDX_RANGE-1:0][POS_W-1:0]   pos_lut_t;

  function automatic layer_lut_t build_layer_lut();
    layer_lut_t lut;
    for (int i = 0; i < IDX_RANGE; i++) begin
      lut[i] = LAYER_W'(i / VOX_PER_LAYER);
    end
    return lut;
  endfunction

  function automatic pos_lut_t build_pos_lut();
    pos_lut_t lut;
    for (int i = 0; i < IDX_RANGE; i++) begin
      lut[i] = POS_W'(i % VOX_PER_LAYER);
    end
    return lut;
  endfunction

  localparam layer_lut_t LAYER_LUT = build_layer_lut();
  localparam pos_lut_t   POS_LUT   = build_pos_lut();

endpackage

/* hw/rtl/lcbfs_in_if.sv */
// Input channel: valid/ready handshake carrying one command word.
interface lcbfs_in_if;
  import lcbfs_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/lcbfs_out_if.sv */
// Output channel: valid/ready handshake carrying one result word.
interface lcbfs_out_if;
  import lcbfs_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/lcbfs_dp.sv */
// Datapath: working and display plane memories, counters, voxel merge and output register.
module lcbfs_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcbfs_pkg::item_t  item_i,
  input  lcbfs_pkg::dp_cmd_t cmd_i,
  output lcbfs_pkg::dp_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lcbfs_pkg::result_t result_o
);
  import lcbfs_pkg::*;

  logic [7:0] wmem [STORE_SIZE];
  logic [7:0] dmem [STORE_SIZE];

  item_t            item_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BYTE_W-1:0] fbyte_q;
  logic [7:0]       wrd_q;
  logic [7:0]       drd_q;
  logic [2:0][3:0]  word_q;
  logic [2:0][3:0]  acc;
  logic             dirty_q;
  logic             copy_v_q;
  logic [ADDR_W-1:0] copy_a_q;
  logic             out_valid_q;
  result_t          result_q;

  logic [LAYER_W-1:0] vox_layer;
  logic [POS_W-1:0]   vox_pos;
  logic [Q_W-1:0]     q_base;
  logic [2:0][Q_W-1:0] q;
  logic [2:0][3:0]    col;
  logic [1:0]         plane;
  logic [BYTE_W-1:0]  byte_lo;
  logic [BYTE_W-1:0]  byte_hi;
  logic [BYTE_W-1:0]  sel_byte;
  logic [ADDR_W-1:0]  vox_addr;
  logic [ADDR_W-1:0]  sh_addr;
  logic [ADDR_W-1:0]  cnt_addr;
  logic [1:0]         sh_plane;
  logic               tick_ok;
  logic [7:0]         merge;
  logic [7:0]         fill_val;

  logic               wm_we;
  logic [ADDR_W-1:0]  wm_waddr;
  logic [7:0]         wm_wdata;
  logic               wm_re;
  logic [ADDR_W-1:0]  wm_raddr;
  logic               dm_we;
  logic [ADDR_W-1:0]  dm_waddr;
  logic [7:0]         dm_wdata;
  logic               dm_re;
  logic [ADDR_W-1:0]  dm_raddr;
  logic               out_free;
  logic               cnt_below_store;

  function automatic logic [ADDR_W-1:0] row_base(logic [LAYER_W-1:0] l, logic [1:0] b);
    return ADDR_W'((int'(l) * PLANES + int'(b)) * BYTES);
  endfunction

  // voxel geometry
  assign vox_layer = LAYER_LUT[item_q.voxel_index];
  assign vox_pos   = POS_LUT[item_q.voxel_index];
  assign q_base    = (Q_W'(vox_pos) << 1) + Q_W'(vox_pos);
  assign q[0]      = q_base;
  assign q[1]      = q_base + Q_W'(1);
  assign q[2]      = q_base + Q_W'(2);
  assign col       = {item_q.blue, item_q.green, item_q.red};
  assign plane     = cnt_q[2:1];
  assign byte_lo   = BYTE_W'(q[0] >> 3);
  assign byte_hi   = BYTE_W'(q[2] >> 3);
  assign sel_byte  = cnt_q[0] ? byte_hi : byte_lo;
  assign vox_addr  = row_base(vox_layer, plane) + ADDR_W'(sel_byte);
  assign cnt_addr  = cnt_q[ADDR_W-1:0];
  assign cnt_below_store = (cnt_q < CNT_W'(STORE_SIZE));

  // tick to bit plane
  always_comb begin
    tick_ok = ~item_q.bam_tick[4];
    if (item_q.bam_tick[3]) begin
      sh_plane = 2'd3;
    end else if (item_q.bam_tick[2]) begin
      sh_plane = 2'd2;
    end else if (item_q.bam_tick[1]) begin
      sh_plane = 2'd1;
    end else begin
      sh_plane = 2'd0;
    end
  end

  assign sh_addr = row_base(item_q.layer_sel[LAYER_W-1:0], sh_plane)
                 + ADDR_W'(BYTES - 1) - ADDR_W'(cnt_q);

  // merge new color bits into a plane byte, gather read bits into the word
  always_comb begin
    merge = wrd_q;
    acc   = word_q;
    for (int c = 0; c < 3; c++) begin
      if (BYTE_W'(q[c] >> 3) == sel_byte) begin
        merge[q[c][2:0]] = col[c][plane];
        acc[c][plane]    = drd_q[q[c][2:0]];
      end
    end
  end

  always_comb begin
    fill_val = (func_e'(item_q.func) == FN_ALL_ON) ? 8'hFF : 8'h00;
    if (func_e'(item_q.func) == FN_ALL_ON && fbyte_q == BYTE_W'(BYTES - 1)) begin
      fill_val = fill_val & PAD_MASK;
    end
  end

  // memory port control
  always_comb begin
    wm_we    = 1'b0;
    wm_waddr = cnt_addr;
    wm_wdata = 8'h00;
    wm_re    = 1'b0;
    wm_raddr = vox_addr;
    dm_we    = copy_v_q;
    dm_waddr = copy_a_q;
    dm_wdata = wrd_q;
    dm_re    = 1'b0;
    dm_raddr = vox_addr;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        wm_we    = 1'b1;
        dm_we    = 1'b1;
        dm_waddr = cnt_addr;
        dm_wdata = 8'h00;
      end
      OP_FILL: begin
        wm_we    = 1'b1;
        wm_wdata = fill_val;
      end
      OP_COPY: begin
        wm_re    = cnt_below_store;
        wm_raddr = cnt_addr;
      end
      OP_WR_RD: begin
        wm_re = 1'b1;
      end
      OP_WR_WR: begin
        wm_we    = 1'b1;
        wm_waddr = vox_addr;
        wm_wdata = merge;
      end
      OP_RD_RD: begin
        dm_re = 1'b1;
      end
      OP_SH_RD: begin
        dm_re    = 1'b1;
        dm_raddr = sh_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      wmem[wm_waddr] <= wm_wdata;
    end
    if (wm_re) begin
      wrd_q <= wmem[wm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      drd_q <= dmem[dm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    copy_a_q <= cnt_addr;
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      fbyte_q  <= '0;
      word_q   <= '0;
      dirty_q  <= 1'b0;
      copy_v_q <= 1'b0;
    end else begin
      copy_v_q <= (cmd_i.op == OP_COPY) && cnt_below_store;
      if (cmd_i.cnt_clr) begin
        cnt_q   <= '0;
        fbyte_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q   <= cnt_q + CNT_W'(1);
        fbyte_q <= (fbyte_q == BYTE_W'(BYTES - 1)) ? '0 : fbyte_q + BYTE_W'(1);
      end
      if (cmd_i.load_item) begin
        word_q <= '0;
      end else if (cmd_i.op == OP_RD_ACC) begin
        word_q <= acc;
      end
      if (cmd_i.dirty_set) begin
        dirty_q <= 1'b1;
      end else if (cmd_i.dirty_clr) begin
        dirty_q <= 1'b0;
      end
    end
  end

  // output register
  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q.dirty <= dirty_q;
      unique case (cmd_i.out_sel)
        OSEL_PLANE: begin
          result_q.color_word <= '0;
          result_q.shift_byte <= drd_q;
          result_q.last       <= 1'b0;
        end
        OSEL_SELECT: begin
          result_q.color_word <= '0;
          result_q.shift_byte <= 8'(1) << item_q.layer_sel;
          result_q.last       <= 1'b1;
        end
        default: begin
          result_q.color_word <= word_q;
          result_q.shift_byte <= '0;
          result_q.last       <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  assign sts_o.func       = func_e'(item_q.func);
  assign sts_o.force_req  = item_q.force_req;
  assign sts_o.in_range   = RANGE_W'(item_q.voxel_index) < RANGE_W'(VOX_TOTAL);
  assign sts_o.shift_ok   = tick_ok && ({1'b0, item_q.layer_sel} < 4'(LAYER_COUNT));
  assign sts_o.step_last  = (cnt_q == CNT_W'(VOX_STEPS - 1));
  assign sts_o.byte_last  = (cnt_q == CNT_W'(BYTES - 1));
  assign sts_o.store_last = (cnt_q == CNT_W'(STORE_SIZE - 1));
  assign sts_o.at_store   = (cnt_q == CNT_W'(STORE_SIZE));
  assign sts_o.out_free   = out_free;

endmodule

/* hw/rtl/lcbfs_ctrl.sv */
// Controller: sequences clear, voxel access, fill, copy and shift-out steps.
module lcbfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output lcbfs_pkg::dp_cmd_t cmd_o,
  input  lcbfs_pkg::dp_sts_t sts_i
);
  import lcbfs_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:    if (sts_i.store_last) state_d = S_IDLE;
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts_i.func)
          FN_WRITE:   state_d = sts_i.in_range ? S_WR_RD : S_RESULT;
          FN_READ:    state_d = sts_i.in_range ? S_RD_RD : S_RESULT;
          FN_ALL_ON,
          FN_ALL_OFF: state_d = S_FILL;
          FN_SYNC:    state_d = S_COPY;
          FN_SHIFT:   state_d = sts_i.shift_ok ? S_SH_RD : S_IDLE;
          default:    state_d = S_IDLE;
        endcase
      end
      S_WR_RD:    state_d = S_WR_WR;
      S_WR_WR:    state_d = sts_i.step_last ? S_RESULT : S_WR_RD;
      S_RD_RD:    state_d = S_RD_ACC;
      S_RD_ACC:   state_d = sts_i.step_last ? S_RESULT : S_RD_RD;
      S_FILL: begin
        if (sts_i.store_last) state_d = sts_i.force_req ? S_COPY : S_RESULT;
      end
      S_COPY:     if (sts_i.at_store) state_d = S_RESULT;
      S_RESULT:   if (sts_i.out_free) state_d = S_IDLE;
      S_SH_RD:    state_d = S_SH_OUT;
      S_SH_OUT: begin
        if (sts_i.out_free) state_d = sts_i.byte_last ? S_SH_SEL : S_SH_RD;
      end
      S_SH_SEL:   if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = OP_IDLE;
    cmd_o.out_sel = OSEL_STATUS;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op      = OP_CLEAR;
        cmd_o.cnt_inc = 1'b1;
      end
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        cmd_o.cnt_clr   = in_valid_i;
      end
      S_WR_RD:  cmd_o.op = OP_WR_RD;
      S_WR_WR: begin
        cmd_o.op        = OP_WR_WR;
        cmd_o.cnt_inc   = ~sts_i.step_last;
        cmd_o.dirty_set = sts_i.step_last;
      end
      S_RD_RD:  cmd_o.op = OP_RD_RD;
      S_RD_ACC: begin
        cmd_o.op      = OP_RD_ACC;
        cmd_o.cnt_inc = ~sts_i.step_last;
      end
      S_FILL: begin
        cmd_o.op        = OP_FILL;
        cmd_o.cnt_inc   = 1'b1;
        cmd_o.dirty_set = sts_i.store_last;
        // restart the counter for the copy sweep
        cmd_o.cnt_clr   = sts_i.store_last;
      end
      S_COPY: begin
        cmd_o.op        = OP_COPY;
        cmd_o.cnt_inc   = ~sts_i.at_store;
        cmd_o.dirty_clr = sts_i.at_store;
      end
      S_RESULT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = OSEL_STATUS;
      end
      S_SH_RD:  cmd_o.op = OP_SH_RD;
      S_SH_OUT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = OSEL_PLANE;
        cmd_o.cnt_inc  = sts_i.out_free & ~sts_i.byte_last;
      end
      S_SH_SEL: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = OSEL_SELECT;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/led_cube_bam_frame_store_top.sv */
// Double-buffered BAM frame store for an RGB LED cube, one command word at a time.
// After reset the block zeroes all STORE_SIZE bytes (96 at the default 4x4x4 cube) of
// both plane memories with in_i.ready low. Commands then run one at a time: a voxel write
// or read takes eight read-modify-write or read steps (two byte visits per plane, each a
// read state, then a write or accumulate state, on the registered-read plane memory); all
// on and all off fill the working store, then copy it to the display store with force_req;
// a sync copies the working store to the display store; a shift reads and sends each plane
// byte in turn. Every command but a shift and the unused codes 6 and 7 returns one
// word with last set; a shift returns BYTES plane bytes, highest first, then the one-hot
// layer byte with last set, and nothing for a tick above 15 or a layer_sel of LAYER_COUNT
// or more. A result waiting in the output register does not hold back the next command.
module led_cube_bam_frame_store_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcbfs_in_if.sink    in_i,
  lcbfs_out_if.source out_o
);
  import lcbfs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    out_valid;
  result_t result;

  lcbfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lcbfs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .result_o    (result)
  );

  assign out_o.valid = out_valid;
  assign out_o.data  = result;

endmodule
